// ===== rtl/rssp_pkg.sv =====
// Shared types and constants for the ring/slice sweep pattern block.
// Used by the configuration, controller, datapath and top-level files.
// No dependencies.
`default_nettype none

package rssp_pkg;

  // field widths
  localparam int ELAPSED_W = 32;
  localparam int COORD_W   = 16;
  localparam int POS_W     = 16;
  localparam int GRID_W    = 8;
  localparam int TIME_W    = 16;

  // step and hold accumulators: below 65535 plus one clamped delta
  localparam int ACC_W = 17;

  // divider iteration counter
  localparam int CNT_W = $clog2(ACC_W);

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // stream payload widths
  localparam int IN_DATA_W  = ELAPSED_W + 2 * COORD_W;
  localparam int OUT_DATA_W = 40;

  // item kinds on in_tuser
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_RING_COUNT  = 3'd0;
  localparam logic [2:0] REG_SLICE_COUNT = 3'd1;
  localparam logic [2:0] REG_FILL_INWARD = 3'd2;
  localparam logic [2:0] REG_STEP_MS     = 3'd3;
  localparam logic [2:0] REG_HOLD_MS     = 3'd4;

  typedef struct packed {
    logic [GRID_W-1:0] ring_count;
    logic [GRID_W-1:0] slice_count;
    logic              fill_inward_first;
    logic [TIME_W-1:0] step_interval_ms;
    logic [TIME_W-1:0] hold_time_ms;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QCELL,
    ST_TDELTA,
    ST_TACC,
    ST_TDIV,
    ST_TAPPLY,
    ST_TDONE
  } state_t;

  // controller to datapath strobes
  typedef struct packed {
    logic load_in;
    logic tick_first;
    logic tick_delta;
    logic hold_upd;
    logic div_load;
    logic div_step;
    logic apply;
    logic out_load;
    logic out_query;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic started;
    logic at_total;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/rssp_cfg.sv =====
// APB-style register file for the sweep pattern settings.
// Depends on rssp_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module rssp_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rssp_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [rssp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [rssp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready,
  output rssp_pkg::cfg_t                      cfg
);

  rssp_pkg::cfg_t cfg_r, cfg_nxt;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[rssp_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        rssp_pkg::REG_RING_COUNT:  cfg_nxt.ring_count        = pwdata[rssp_pkg::GRID_W-1:0];
        rssp_pkg::REG_SLICE_COUNT: cfg_nxt.slice_count       = pwdata[rssp_pkg::GRID_W-1:0];
        rssp_pkg::REG_FILL_INWARD: cfg_nxt.fill_inward_first = pwdata[0];
        rssp_pkg::REG_STEP_MS:     cfg_nxt.step_interval_ms  = pwdata[rssp_pkg::TIME_W-1:0];
        rssp_pkg::REG_HOLD_MS:     cfg_nxt.hold_time_ms      = pwdata[rssp_pkg::TIME_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ring_count        <= rssp_pkg::GRID_W'(1);
      cfg_r.slice_count       <= rssp_pkg::GRID_W'(1);
      cfg_r.fill_inward_first <= 1'b0;
      cfg_r.step_interval_ms  <= rssp_pkg::TIME_W'(1);
      cfg_r.hold_time_ms      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      rssp_pkg::REG_RING_COUNT:
        prdata = {{(rssp_pkg::CFG_DATA_W-rssp_pkg::GRID_W){1'b0}}, cfg_r.ring_count};
      rssp_pkg::REG_SLICE_COUNT:
        prdata = {{(rssp_pkg::CFG_DATA_W-rssp_pkg::GRID_W){1'b0}}, cfg_r.slice_count};
      rssp_pkg::REG_FILL_INWARD:
        prdata = {{(rssp_pkg::CFG_DATA_W-1){1'b0}}, cfg_r.fill_inward_first};
      rssp_pkg::REG_STEP_MS:
        prdata = {{(rssp_pkg::CFG_DATA_W-rssp_pkg::TIME_W){1'b0}}, cfg_r.step_interval_ms};
      rssp_pkg::REG_HOLD_MS:
        prdata = {{(rssp_pkg::CFG_DATA_W-rssp_pkg::TIME_W){1'b0}}, cfg_r.hold_time_ms};
      default:
        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rssp_ctrl.sv =====
// Controller state machine for the sweep pattern: sequences queries, ticks
// and the step divider, and owns the stream handshakes. Depends on rssp_pkg.
`default_nettype none

module rssp_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_cmd,
  output logic              in_tready,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output rssp_pkg::dp_cmd_t cmd,
  input  wire rssp_pkg::dp_sts_t sts
);

  rssp_pkg::state_t            state_r, state_nxt;
  logic [rssp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        in_acc;
  logic                        slot_free;

  assign in_tready  = (state_r == rssp_pkg::ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign slot_free  = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rssp_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_cmd == rssp_pkg::CMD_QUERY) ? rssp_pkg::ST_QCELL
                                                      : rssp_pkg::ST_TDELTA;
        end
      end
      rssp_pkg::ST_QCELL: begin
        if (slot_free) state_nxt = rssp_pkg::ST_IDLE;
      end
      rssp_pkg::ST_TDELTA: begin
        state_nxt = sts.started ? rssp_pkg::ST_TACC : rssp_pkg::ST_TDONE;
      end
      rssp_pkg::ST_TACC: begin
        state_nxt = sts.at_total ? rssp_pkg::ST_TDONE : rssp_pkg::ST_TDIV;
      end
      rssp_pkg::ST_TDIV: begin
        if (cnt_r == '0) state_nxt = rssp_pkg::ST_TAPPLY;
      end
      rssp_pkg::ST_TAPPLY: begin
        state_nxt = rssp_pkg::ST_TDONE;
      end
      rssp_pkg::ST_TDONE: begin
        if (slot_free) state_nxt = rssp_pkg::ST_IDLE;
      end
      default: state_nxt = rssp_pkg::ST_IDLE;
    endcase
  end

  // datapath strobes
  always_comb begin
    cmd            = '0;
    cmd.load_in    = in_acc;
    cmd.tick_first = (state_r == rssp_pkg::ST_TDELTA) & ~sts.started;
    cmd.tick_delta = (state_r == rssp_pkg::ST_TDELTA) &  sts.started;
    cmd.hold_upd   = (state_r == rssp_pkg::ST_TACC)   &  sts.at_total;
    cmd.div_load   = (state_r == rssp_pkg::ST_TACC)   & ~sts.at_total;
    cmd.div_step   = (state_r == rssp_pkg::ST_TDIV);
    cmd.apply      = (state_r == rssp_pkg::ST_TAPPLY);
    cmd.out_query  = (state_r == rssp_pkg::ST_QCELL);
    cmd.out_load   = ((state_r == rssp_pkg::ST_QCELL) | (state_r == rssp_pkg::ST_TDONE))
                     & slot_free;
  end

  // divider iteration count and output valid
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.div_load) begin
      cnt_nxt = rssp_pkg::CNT_W'(rssp_pkg::ACC_W - 1);
    end else if (cmd.div_step) begin
      cnt_nxt = cnt_r - rssp_pkg::CNT_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rssp_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rssp_dp.sv =====
// Datapath for the sweep pattern: sweep state, query cell lookup, tick delta,
// restoring step divider and the output register. Depends on rssp_pkg.
`default_nettype none

module rssp_dp #(
  parameter int MAX_DELTA_MS = 250
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire rssp_pkg::cfg_t                 cfg,
  input  wire rssp_pkg::dp_cmd_t              cmd,
  output rssp_pkg::dp_sts_t                   sts,
  input  wire logic [rssp_pkg::ELAPSED_W-1:0] in_elapsed_ms,
  input  wire logic [rssp_pkg::COORD_W-1:0]   in_angle,
  input  wire logic [rssp_pkg::COORD_W-1:0]   in_radius,
  output logic      [rssp_pkg::COORD_W-1:0]   out_intensity,
  output logic      [rssp_pkg::POS_W-1:0]     out_lit_count,
  output logic                                out_holding,
  output logic                                out_running
);

  localparam int DT_W = (MAX_DELTA_MS < 2) ? 1 : $clog2(MAX_DELTA_MS + 1);
  localparam logic [rssp_pkg::ELAPSED_W-1:0] MAX_DELTA = rssp_pkg::ELAPSED_W'(MAX_DELTA_MS);
  localparam int ACC_W = rssp_pkg::ACC_W;
  localparam int GW    = rssp_pkg::GRID_W;
  localparam int CW    = rssp_pkg::COORD_W;
  localparam int PW    = rssp_pkg::POS_W;
  localparam int TW    = rssp_pkg::TIME_W;

  // sweep state
  logic                            started_r, started_nxt;
  logic [PW-1:0]                   pos_r, pos_nxt;
  logic [rssp_pkg::ELAPSED_W-1:0]  last_time_r, last_time_nxt;
  logic [ACC_W-1:0]                step_acc_r, step_acc_nxt;
  logic [ACC_W-1:0]                hold_acc_r, hold_acc_nxt;

  // per-item working registers
  logic [rssp_pkg::ELAPSED_W-1:0]  elapsed_r;
  logic [CW-1:0]                   angle_r;
  logic [GW-1:0]                   ring_r, slice_r;
  logic [DT_W-1:0]                 dt_r;
  logic [PW-1:0]                   total_r;
  logic [TW-1:0]                   rem_r;
  logic [ACC_W-1:0]                quo_r;

  // output register
  logic [CW-1:0]                   intensity_r;
  logic [PW-1:0]                   lit_count_r;
  logic                            holding_r, running_r;

  logic [GW-1:0]                   rings_eff, slices_eff, fill_ring;
  logic [TW-1:0]                   interval_eff;
  logic [CW+GW-1:0]                ring_prod, slice_prod;
  logic [PW-1:0]                   cell_idx;
  logic                            lit;
  logic [rssp_pkg::ELAPSED_W-1:0]  diff;
  logic [DT_W-1:0]                 dt;
  logic [ACC_W-1:0]                dt_ext, hold_sum, acc_sum;
  logic [TW:0]                     trial, trial_sub;
  logic                            trial_ge;
  logic [PW-1:0]                   left;
  logic                            at_total;

  // zero-valued settings act as one
  assign rings_eff    = (cfg.ring_count  == '0) ? GW'(1) : cfg.ring_count;
  assign slices_eff   = (cfg.slice_count == '0) ? GW'(1) : cfg.slice_count;
  assign interval_eff = (cfg.step_interval_ms == '0) ? TW'(1) : cfg.step_interval_ms;

  // query ring and slice from the incoming coordinates
  assign ring_prod  = {{GW{1'b0}}, in_radius} * {{CW{1'b0}}, rings_eff};
  assign slice_prod = {{GW{1'b0}}, in_angle}  * {{CW{1'b0}}, slices_eff};

  // cell index in fill order and lit test
  assign fill_ring = cfg.fill_inward_first ? ring_r : (rings_eff - GW'(1) - ring_r);
  assign cell_idx  = ({{(PW-GW){1'b0}}, fill_ring} * {{(PW-GW){1'b0}}, slices_eff})
                     + {{(PW-GW){1'b0}}, slice_r};
  assign lit       = started_r & (pos_r >= cell_idx);

  // clamped tick delta
  assign diff = elapsed_r - last_time_r;
  always_comb begin
    if (elapsed_r < last_time_r) begin
      dt = '0;
    end else if (diff > MAX_DELTA) begin
      dt = DT_W'(MAX_DELTA_MS);
    end else begin
      dt = diff[DT_W-1:0];
    end
  end

  assign dt_ext   = {{(ACC_W-DT_W){1'b0}}, dt_r};
  assign hold_sum = hold_acc_r + dt_ext;
  assign acc_sum  = step_acc_r + dt_ext;
  assign at_total = (pos_r >= total_r);
  assign left     = total_r - pos_r;

  // one restoring division step
  assign trial     = {rem_r, quo_r[ACC_W-1]};
  assign trial_ge  = (trial >= {1'b0, interval_eff});
  assign trial_sub = trial - {1'b0, interval_eff};

  assign sts.started  = started_r;
  assign sts.at_total = at_total;

  // sweep state update
  always_comb begin
    started_nxt   = started_r;
    pos_nxt       = pos_r;
    last_time_nxt = last_time_r;
    step_acc_nxt  = step_acc_r;
    hold_acc_nxt  = hold_acc_r;
    if (cmd.tick_first) begin
      started_nxt   = 1'b1;
      last_time_nxt = elapsed_r;
      pos_nxt       = '0;
      step_acc_nxt  = '0;
      hold_acc_nxt  = '0;
    end
    if (cmd.tick_delta) begin
      last_time_nxt = elapsed_r;
    end
    if (cmd.hold_upd) begin
      if (hold_sum >= {{(ACC_W-TW){1'b0}}, cfg.hold_time_ms}) begin
        pos_nxt      = '0;
        step_acc_nxt = '0;
        hold_acc_nxt = '0;
      end else begin
        hold_acc_nxt = hold_sum;
      end
    end
    if (cmd.apply) begin
      if (quo_r >= {{(ACC_W-PW){1'b0}}, left}) begin
        pos_nxt      = total_r;
        step_acc_nxt = '0;
        hold_acc_nxt = '0;
      end else begin
        pos_nxt      = pos_r + quo_r[PW-1:0];
        step_acc_nxt = {{(ACC_W-TW){1'b0}}, rem_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      pos_r       <= '0;
      last_time_r <= '0;
      step_acc_r  <= '0;
      hold_acc_r  <= '0;
    end else begin
      started_r   <= started_nxt;
      pos_r       <= pos_nxt;
      last_time_r <= last_time_nxt;
      step_acc_r  <= step_acc_nxt;
      hold_acc_r  <= hold_acc_nxt;
    end
  end

  // item capture, delta, divider and total
  always_ff @(posedge clk) begin
    total_r <= {{(PW-GW){1'b0}}, rings_eff} * {{(PW-GW){1'b0}}, slices_eff};
    if (cmd.load_in) begin
      elapsed_r <= in_elapsed_ms;
      angle_r   <= in_angle;
      ring_r    <= ring_prod[CW+GW-1:CW];
      slice_r   <= slice_prod[CW+GW-1:CW];
    end
    if (cmd.tick_delta) begin
      dt_r <= dt;
    end
    if (cmd.div_load) begin
      rem_r <= '0;
      quo_r <= acc_sum;
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? trial_sub[TW-1:0] : trial[TW-1:0];
      quo_r <= {quo_r[ACC_W-2:0], trial_ge};
    end
  end

  // output register, loaded after the state update
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      intensity_r <= (cmd.out_query && lit) ? angle_r : '0;
      lit_count_r <= pos_r;
      holding_r   <= started_r & at_total;
      running_r   <= started_r;
    end
  end

  assign out_intensity = intensity_r;
  assign out_lit_count = lit_count_r;
  assign out_holding   = holding_r;
  assign out_running   = running_r;

endmodule

`default_nettype wire

// ===== rtl/ring_slice_sweep_pattern.sv =====
// Ring-by-slice sweep pattern, top level: stream ports, APB settings port,
// controller and datapath. Depends on rssp_pkg, rssp_cfg, rssp_ctrl, rssp_dp.
//
// One item in, one result out. A pixel query (in_tuser = 1) goes from acceptance
// through the cell lookup state to the result register. A frame tick (in_tuser = 0)
// reaches the result register through the delta state when it is the first tick,
// also through the accumulate state while the sweep holds fully lit, and also through
// the divide and apply states while the sweep runs: the step count comes from a
// 17-iteration restoring divider that retires one quotient bit a cycle. A result
// that is not taken holds the block in its last state until out_tready. The next item
// is taken once the current one has been placed in the output register, so one result
// may wait while the next item is already at work. No clearing pass after reset.
`default_nettype none

module ring_slice_sweep_pattern #(
  parameter int MAX_DELTA_MS = 250
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // tdata: elapsed_ms[31:0], angle[47:32], radius[63:48]
  input  wire logic [rssp_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: cmd[0]
  input  wire logic [0:0]                      in_tuser,
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // tdata: intensity[15:0], lit_count[31:16], holding[32], running[33], zeros[39:34]
  output logic      [rssp_pkg::OUT_DATA_W-1:0] out_tdata,
  // settings port
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [rssp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [rssp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [rssp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int EW = rssp_pkg::ELAPSED_W;
  localparam int CW = rssp_pkg::COORD_W;
  localparam int PW = rssp_pkg::POS_W;

  rssp_pkg::cfg_t    cfg;
  rssp_pkg::dp_cmd_t dp_cmd;
  rssp_pkg::dp_sts_t dp_sts;

  logic [CW-1:0] intensity;
  logic [PW-1:0] lit_count;
  logic          holding, running;

  rssp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  rssp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser[0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (dp_cmd),
    .sts        (dp_sts)
  );

  rssp_dp #(
    .MAX_DELTA_MS (MAX_DELTA_MS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (dp_cmd),
    .sts           (dp_sts),
    .in_elapsed_ms (in_tdata[EW-1:0]),
    .in_angle      (in_tdata[EW+CW-1:EW]),
    .in_radius     (in_tdata[EW+2*CW-1:EW+CW]),
    .out_intensity (intensity),
    .out_lit_count (lit_count),
    .out_holding   (holding),
    .out_running   (running)
  );

  // pack the result fields, lowest field first
  assign out_tdata = {{(rssp_pkg::OUT_DATA_W-CW-PW-2){1'b0}}, running, holding,
                      lit_count, intensity};

endmodule

`default_nettype wire
